// ----- sv/utp_pkg.sv -----
package utp_pkg;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_16      = 2'd1,
      KIND_32      = 2'd2,
      KIND_128     = 2'd3
   } kind_type;

   localparam logic [5:0] COUNT_MAX = 6'd63;
   localparam logic [5:0] LONG_BODY = 6'd36;
   localparam logic [5:0] LEN_16    = 6'd4;
   localparam logic [5:0] LEN_32    = 6'd8;
   localparam logic [5:0] PREFIX_LEN = 6'd2;

   localparam logic [5:0] DASH_OFF_0 = 6'd8;
   localparam logic [5:0] DASH_OFF_1 = 6'd13;
   localparam logic [5:0] DASH_OFF_2 = 6'd18;
   localparam logic [5:0] DASH_OFF_3 = 6'd23;

   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;

   localparam int unsigned TDATA_PAD = 6;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
      logic       is_dash;
      logic       is_x;
      logic       is_zero;
   } char_class_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] value_low;
      logic [63:0] value_high;
   } result_type;

endpackage

// ----- sv/uuid_text_parser_unit.sv -----
// Channel | Direction | Transaction content
// req_*   | in        | tdata[7:0] char_code, tlast last_char
// rsp_*   | out       | tdata: kind[1:0], value_low[65:2], value_high[129:66], zero pad
//
// One character per cycle is taken unless a last character waits on a stalled
// result; a character is scanned from the input register, and a string's result
// is held in the output register once its last character has been scanned.
// reset is synchronous and clears the scan state and both valid flags.
// A stalled result holds back the last character of the next string, and with it
// all input after it; the characters before it keep flowing.
module uuid_text_parser_unit (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] char_code
   input  logic           req_tlast,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [135:0]   rsp_tdata    // [1:0] kind, [65:2] value_low, [129:66] value_high
);
   import utp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff;

   logic           out_free;
   logic           advance;
   logic           req_take;
   char_class_type cls;
   result_type     result;

   utp_char_class u_class (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   utp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .last_char (in_last_ff),
      .cls       (cls),
      .result    (result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      advance      = in_valid_ff && (!in_last_ff || out_free);
      req_tready   = !in_valid_ff || advance;
      req_take     = req_tvalid && req_tready;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = (advance && in_last_ff) ? 1'b1 :
                     (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      // Hold the result until the sink takes it.
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{TDATA_PAD{1'b0}}, rsp_data_ff.value_high,
                        rsp_data_ff.value_low, rsp_data_ff.kind};

endmodule

// ----- sv/utp_char_class.sv -----
module utp_char_class (
   input  logic [7:0]              char_code,
   output utp_pkg::char_class_type cls
);
   import utp_pkg::*;

   logic [7:0] dec_off;
   logic [7:0] lo_off;
   logic [7:0] up_off;

   always_comb begin
      dec_off = char_code - CHAR_ZERO;
      lo_off  = char_code - CHAR_LA + 8'd10;
      up_off  = char_code - CHAR_UA + 8'd10;

      cls.is_dash = (char_code == CHAR_DASH);
      cls.is_x    = (char_code == CHAR_LX) || (char_code == CHAR_UX);
      cls.is_zero = (char_code == CHAR_ZERO);
      cls.is_hex  = 1'b1;
      cls.nibble  = 4'd0;
      if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
         cls.nibble = dec_off[3:0];
      end else if (char_code >= CHAR_LA && char_code <= CHAR_LF) begin
         cls.nibble = lo_off[3:0];
      end else if (char_code >= CHAR_UA && char_code <= CHAR_UF) begin
         cls.nibble = up_off[3:0];
      end else begin
         cls.is_hex = 1'b0;
      end
   end

endmodule

// ----- sv/utp_scan.sv -----
module utp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    last_char,
   input  utp_pkg::char_class_type cls,
   output utp_pkg::result_type     result
);
   import utp_pkg::*;

   logic [63:0] shift_lo_ff, shift_lo_in;
   logic [63:0] shift_hi_ff, shift_hi_in;
   logic [5:0]  count_ff, count_in;
   logic        first_zero_ff, first_zero_in;
   logic        prefix_ff, prefix_in;
   logic        hex_ok_ff, hex_ok_in;
   logic        dash_ok_ff, dash_ok_in;

   logic        take_prefix;
   logic        body;
   logic [5:0]  offset;
   logic        dash_slot;
   logic [3:0]  digit;
   logic [5:0]  body_len;

   always_comb begin
      take_prefix = (count_ff == 6'd1) && first_zero_ff && cls.is_x;
      prefix_in   = prefix_ff | take_prefix;
      body        = !take_prefix && (count_ff != COUNT_MAX);
      offset      = prefix_ff ? count_ff - PREFIX_LEN : count_ff;
      dash_slot   = (offset == DASH_OFF_0) || (offset == DASH_OFF_1) ||
                    (offset == DASH_OFF_2) || (offset == DASH_OFF_3);
      digit       = cls.is_hex ? cls.nibble : 4'd0;

      shift_lo_in = take_prefix ? 64'd0 : shift_lo_ff;
      shift_hi_in = take_prefix ? 64'd0 : shift_hi_ff;
      hex_ok_in   = hex_ok_ff;
      dash_ok_in  = dash_ok_ff;

      if (body) begin
         if (dash_slot) begin
            if (!cls.is_dash) dash_ok_in = 1'b0;
         end else begin
            shift_hi_in = {shift_hi_ff[59:0], shift_lo_ff[63:60]};
            shift_lo_in = {shift_lo_ff[59:0], digit};
            if (!cls.is_hex) hex_ok_in = 1'b0;
         end
      end

      first_zero_in = (count_ff == 6'd0) ? cls.is_zero : first_zero_ff;
      count_in      = (count_ff == COUNT_MAX) ? count_ff : count_ff + 6'd1;
   end

   // Judge the finished string from the updated state.
   always_comb begin
      body_len          = prefix_in ? count_in - PREFIX_LEN : count_in;
      result.kind       = KIND_INVALID;
      result.value_low  = 64'd0;
      result.value_high = 64'd0;
      if (count_in != COUNT_MAX && hex_ok_in) begin
         if (body_len == LEN_16) begin
            result.kind      = KIND_16;
            result.value_low = {48'd0, shift_lo_in[15:0]};
         end else if (body_len == LEN_32) begin
            result.kind      = KIND_32;
            result.value_low = {32'd0, shift_lo_in[31:0]};
         end else if (body_len == LONG_BODY && dash_ok_in) begin
            result.kind       = KIND_128;
            result.value_low  = shift_lo_in;
            result.value_high = shift_hi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last_char)) begin
         shift_lo_ff   <= 64'd0;
         shift_hi_ff   <= 64'd0;
         count_ff      <= 6'd0;
         first_zero_ff <= 1'b0;
         prefix_ff     <= 1'b0;
         hex_ok_ff     <= 1'b1;
         dash_ok_ff    <= 1'b1;
      end else if (step_en) begin
         shift_lo_ff   <= shift_lo_in;
         shift_hi_ff   <= shift_hi_in;
         count_ff      <= count_in;
         first_zero_ff <= first_zero_in;
         prefix_ff     <= prefix_in;
         hex_ok_ff     <= hex_ok_in;
         dash_ok_ff    <= dash_ok_in;
      end
   end

endmodule
